// File: hdl/bitonic_array_search_unit_assert.svh
// ----------------------------------------------------------------------------
// Bitonic array search assertion macros
// Shared property forms for the checker, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef BITONIC_ARRAY_SEARCH_UNIT_ASSERT_SVH
`define BITONIC_ARRAY_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define BAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bas_pkg.sv
// ----------------------------------------------------------------------------
// Bitonic array search package
// Shared widths, command codes and the sequencer state type.
// ----------------------------------------------------------------------------
package bas_pkg;

    localparam int LEN_W       = 11;   // array_length register
    localparam int IDX_W       = 12;   // internal search index, holds up to 2047
    localparam int OUT_IDX_W   = 10;   // index fields of a result
    localparam int IN_ADDR_W   = 10;
    localparam int IN_VAL_W    = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;
    localparam int LEN_LIMIT   = 2047;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEAK,
        ST_PVAL,
        ST_RISE,
        ST_FALL,
        ST_DONE
    } state_t;

endpackage

// File: hdl/bas_store.sv
// ----------------------------------------------------------------------------
// Bitonic array search element store
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module bas_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int VW    = 32
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [VW-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr_a,
    input  logic [AW-1:0]        rd_addr_b,
    output logic signed [VW-1:0] rd_data_a,
    output logic signed [VW-1:0] rd_data_b
);

    logic signed [VW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: hdl/bitonic_array_search_unit.sv
// ----------------------------------------------------------------------------
// Bitonic array search unit
// Loads signed words into a store; a search finds the peak, then looks for a
// value on the rising and on the falling side of it.
// ----------------------------------------------------------------------------
//  channel   | direction | carries
//  s_axis    | in        | load or search item (tuser = command)
//  m_axis    | out       | one result per search item
//  cfg       | in        | array_length write
//
// A load leaves the input ready for the next item. A search makes one probe
// per cycle through the dual-read store, whose registered read sits in the
// loop. No item is taken while a search runs; a finished result waits in the
// output register while the next item is accepted. rst_n clears control state
// only; the store holds garbage until written.
// ----------------------------------------------------------------------------
module bitonic_array_search_unit #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [9:0] load_address, [41:10] element_value, [73:42] search_value
    input  logic [bas_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [9:0] peak_index, [10] peak_matches, [11] rising_found,
    // [21:12] rising_index, [22] falling_found, [32:23] falling_index
    output logic [bas_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [bas_pkg::LEN_W-1:0]        cfg_wdata
);

    import bas_pkg::*;

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM = (DEPTH > LEN_LIMIT) ? LEN_LIMIT : DEPTH;

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         len_reg;
    logic [IDX_W-1:0]         lo_reg, lo_next;
    logic [IDX_W-1:0]         hi_reg, hi_next;
    logic [IDX_W-1:0]         mid_reg, mid_next;
    logic                     pend_reg, pend_next;
    logic [IDX_W-1:0]         n_reg, n_next;
    logic signed [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [IDX_W-1:0]         peak_reg, peak_next;
    logic                     match_reg, match_next;
    logic                     rfound_reg, rfound_next;
    logic [IDX_W-1:0]         ridx_reg, ridx_next;
    logic                     ffound_reg, ffound_next;
    logic [IDX_W-1:0]         fidx_reg, fidx_next;
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [VALUE_WIDTH-1:0] wr_data;
    logic [IDX_W-1:0]         rd_idx_a, rd_idx_b;
    logic signed [VALUE_WIDTH-1:0] rd_data_a, rd_data_b;

    logic                     in_accept;
    logic [IN_ADDR_W-1:0]     in_addr;
    logic signed [IN_VAL_W-1:0] in_elem;
    logic signed [IN_VAL_W-1:0] in_search;
    logic [LEN_W-1:0]         n_eff;
    logic [IDX_W-1:0]         lo_c, hi_c, mid_c;
    logic                     hit;
    logic                     asc;

    assign in_addr   = s_axis_tdata[9:0];
    assign in_elem   = s_axis_tdata[41:10];
    assign in_search = s_axis_tdata[73:42];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // zero length counts as one, too long saturates to the store depth or 2047, whichever is smaller
    always_comb
    begin
        if (len_reg == '0)
        begin
            n_eff = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(LIM))
        begin
            n_eff = LEN_W'(LIM);
        end
        else
        begin
            n_eff = len_reg;
        end
    end

    assign wr_addr = AW'(in_addr);
    assign wr_data = VALUE_WIDTH'(in_elem);

    bas_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .VW    (VALUE_WIDTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (AW'(rd_idx_a)),
        .rd_addr_b (AW'(rd_idx_b)),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= LEN_W'(1);
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        n_reg      <= n_next;
        val_reg    <= val_next;
        peak_reg   <= peak_next;
        match_reg  <= match_next;
        rfound_reg <= rfound_next;
        ridx_reg   <= ridx_next;
        ffound_reg <= ffound_next;
        fidx_reg   <= fidx_next;
        m_data_reg <= m_data_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        pend_next    = pend_reg;
        n_next       = n_reg;
        val_next     = val_reg;
        peak_next    = peak_reg;
        match_next   = match_reg;
        rfound_next  = rfound_reg;
        ridx_next    = ridx_reg;
        ffound_next  = ffound_reg;
        fidx_next    = fidx_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        rd_idx_a     = mid_reg;
        rd_idx_b     = mid_reg + 1'b1;
        lo_c         = lo_reg;
        hi_c         = hi_reg;
        mid_c        = mid_reg;
        hit          = 1'b0;
        asc          = (state_reg == ST_RISE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == CMD_SEARCH)
                    begin
                        val_next   = VALUE_WIDTH'(in_search);
                        n_next     = IDX_W'(n_eff);
                        lo_next    = '0;
                        hi_next    = IDX_W'(n_eff) - 1'b1;
                        pend_next  = 1'b0;
                        state_next = ST_PEAK;
                    end
                    else if (32'(in_addr) < DEPTH)
                    begin
                        wr_en = 1'b1;
                    end
                end
            end

            // window [lo, hi] inclusive; probe mid against mid + 1
            ST_PEAK:
            begin
                if (pend_reg)
                begin
                    if (rd_data_a < rd_data_b)
                    begin
                        lo_c = mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_c = mid_reg;
                    end
                end
                if (lo_c < hi_c)
                begin
                    mid_c     = lo_c + ((hi_c - lo_c) >> 1);
                    rd_idx_a  = mid_c;
                    rd_idx_b  = mid_c + 1'b1;
                    lo_next   = lo_c;
                    hi_next   = hi_c;
                    mid_next  = mid_c;
                    pend_next = 1'b1;
                end
                else
                begin
                    peak_next  = lo_c;
                    rd_idx_b   = lo_c;
                    pend_next  = 1'b0;
                    state_next = ST_PVAL;
                end
            end

            ST_PVAL:
            begin
                match_next = (rd_data_b == val_reg);
                lo_next    = '0;
                hi_next    = peak_reg;
                pend_next  = 1'b0;
                state_next = ST_RISE;
            end

            // window [lo, hi) exclusive; stop at the first equal probe
            ST_RISE, ST_FALL:
            begin
                if (pend_reg)
                begin
                    if (rd_data_a == val_reg)
                    begin
                        hit = 1'b1;
                    end
                    else if ((rd_data_a < val_reg) == asc)
                    begin
                        lo_c = mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_c = mid_reg;
                    end
                end
                if (!hit && (lo_c < hi_c))
                begin
                    mid_c     = lo_c + ((hi_c - lo_c - 1'b1) >> 1);
                    rd_idx_a  = mid_c;
                    lo_next   = lo_c;
                    hi_next   = hi_c;
                    mid_next  = mid_c;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (asc)
                    begin
                        rfound_next = hit;
                        ridx_next   = hit ? mid_reg : '0;
                        lo_next     = peak_reg + 1'b1;
                        hi_next     = n_reg;
                        state_next  = ST_FALL;
                    end
                    else
                    begin
                        ffound_next = hit;
                        fidx_next   = hit ? mid_reg : '0;
                        state_next  = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0,
                                    fidx_reg[OUT_IDX_W-1:0], ffound_reg,
                                    ridx_reg[OUT_IDX_W-1:0], rfound_reg,
                                    match_reg, peak_reg[OUT_IDX_W-1:0]};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/bas_checker.sv
// ----------------------------------------------------------------------------
// Bitonic array search port checker
// Watches the top-level ports for sequencing and result consistency.
// ----------------------------------------------------------------------------
`include "bitonic_array_search_unit_assert.svh"

module bas_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bas_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import bas_pkg::*;

    logic search_acc;
    logic load_acc;

    assign search_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_SEARCH);
    assign load_acc   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD);

    // a search occupies the sequencer
    `BAS_ASSERT_NEXT(a_search_blocks, search_acc, !s_axis_tready, "search item not blocking")

    // a load finishes in its own cycle
    `BAS_ASSERT_NEXT(a_load_one_cycle, load_acc, s_axis_tready, "load item held the input")

    // a side that found nothing reports index zero
    `BAS_ASSERT_NOW(a_empty_index, m_axis_tvalid, (m_axis_tdata[11] || (m_axis_tdata[21:12] == '0)) && (m_axis_tdata[22] || (m_axis_tdata[32:23] == '0)), "nonzero index without a hit")

    `BAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind bitonic_array_search_unit bas_checker u_bas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
